// ===== sv/hsr_pkg.sv =====
`default_nettype none
package hsr_pkg;

	localparam int CORDIC_STAGES_DEF = 30;
	localparam int CW = 34;
	localparam int SQRT_STEPS = 31;
	localparam logic [22:0] RADIUS_RESET = 23'd6371000;
	localparam logic [31:0] PI_Q30 = 32'd3373259426;
	localparam logic [34:0] RANGE_MAX = '1;

	typedef logic signed [CW-1:0] q30_t;

	// atan(2^-i) in q30, rounded
	function automatic q30_t atan_q30(input int i);
		q30_t r;
		case (i)
			0: r = 34'sd843314857;
			1: r = 34'sd497837829;
			2: r = 34'sd263043837;
			3: r = 34'sd133525159;
			4: r = 34'sd67021687;
			5: r = 34'sd33543516;
			6: r = 34'sd16775851;
			7: r = 34'sd8388437;
			8: r = 34'sd4194283;
			9: r = 34'sd2097149;
			default: begin
				if (i <= 30) r = q30_t'(1) <<< (30 - i);
				else if (i == 31) r = 34'sd1;
				else r = '0;
			end
		endcase
		return r;
	endfunction

	// final x of vectoring (2^31, 0) through n stages, used for the gain constant
	function automatic longint cordic_gain_x(input int n);
		longint x;
		longint y;
		longint nx;
		int s;
		x = longint'(1) <<< 31;
		y = 0;
		for (int i = 0; i < n; i++) begin
			s = (i > 63) ? 63 : i;
			if (y >= 0) begin
				nx = x + (y >>> s);
				y = y - (x >>> s);
			end else begin
				nx = x - (y >>> s);
				y = y + (x >>> s);
			end
			x = nx;
		end
		return x;
	endfunction

	// q30 product, rounded half away from zero
	function automatic q30_t mul_q30(input q30_t a, input q30_t b);
		logic [32:0] ma;
		logic [32:0] mb;
		logic [65:0] p;
		q30_t r;
		ma = a[CW-1] ? 33'(-a) : 33'(a);
		mb = b[CW-1] ? 33'(-b) : 33'(b);
		p = 66'(ma) * 66'(mb) + (66'd1 << 29);
		r = q30_t'({1'b0, p[62:30]});
		return (a[CW-1] ^ b[CW-1]) ? -r : r;
	endfunction

endpackage
`default_nettype wire

// ===== sv/hsr_rot_cordic.sv =====
`default_nettype none
module hsr_rot_cordic #(
	parameter int STAGES = hsr_pkg::CORDIC_STAGES_DEF,
	parameter int SIDE_W = 1,
	parameter hsr_pkg::q30_t X_INIT = '0
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              en,
	input  wire logic              v_in,
	input  wire hsr_pkg::q30_t     z_in,
	input  wire logic [SIDE_W-1:0] side_in,
	output logic                   v_out,
	output hsr_pkg::q30_t          x_out,
	output hsr_pkg::q30_t          y_out,
	output logic [SIDE_W-1:0]      side_out
);
	import hsr_pkg::*;

	q30_t              x_s    [STAGES];
	q30_t              y_s    [STAGES];
	q30_t              z_s    [STAGES];
	logic              v_s    [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		q30_t              xp;
		q30_t              yp;
		q30_t              zp;
		logic              vp;
		logic [SIDE_W-1:0] sp;

		if (i == 0) begin : g_head
			assign xp = X_INIT;
			assign yp = '0;
			assign zp = z_in;
			assign vp = v_in;
			assign sp = side_in;
		end else begin : g_tail
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
			assign sp = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!zp[CW-1]) begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_q30(i);
				end else begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_q30(i);
				end
				side_s[i] <= sp;
			end
		end
	end

	assign v_out = v_s[STAGES-1];
	assign x_out = x_s[STAGES-1];
	assign y_out = y_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule
`default_nettype wire

// ===== sv/hsr_vec_cordic.sv =====
`default_nettype none
module hsr_vec_cordic #(
	parameter int STAGES = hsr_pkg::CORDIC_STAGES_DEF,
	parameter int W = hsr_pkg::CW,
	parameter int SIDE_W = 1
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                en,
	input  wire logic                v_in,
	input  wire logic signed [W-1:0] x_in,
	input  wire logic signed [W-1:0] y_in,
	input  wire logic [SIDE_W-1:0]   side_in,
	output logic                     v_out,
	output logic signed [W-1:0]      x_out,
	output hsr_pkg::q30_t            z_out,
	output logic [SIDE_W-1:0]        side_out
);
	import hsr_pkg::*;

	typedef logic signed [W-1:0] word_t;

	word_t             x_s    [STAGES];
	word_t             y_s    [STAGES];
	q30_t              z_s    [STAGES];
	logic              v_s    [STAGES];
	logic [SIDE_W-1:0] side_s [STAGES];

	for (genvar i = 0; i < STAGES; i++) begin : g_stage
		word_t             xp;
		word_t             yp;
		q30_t              zp;
		logic              vp;
		logic [SIDE_W-1:0] sp;

		if (i == 0) begin : g_head
			assign xp = x_in;
			assign yp = y_in;
			assign zp = '0;
			assign vp = v_in;
			assign sp = side_in;
		end else begin : g_tail
			assign xp = x_s[i-1];
			assign yp = y_s[i-1];
			assign zp = z_s[i-1];
			assign vp = v_s[i-1];
			assign sp = side_s[i-1];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[i] <= 1'b0;
			else if (en) v_s[i] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (!yp[W-1]) begin
					x_s[i] <= xp + (yp >>> i);
					y_s[i] <= yp - (xp >>> i);
					z_s[i] <= zp + atan_q30(i);
				end else begin
					x_s[i] <= xp - (yp >>> i);
					y_s[i] <= yp + (xp >>> i);
					z_s[i] <= zp - atan_q30(i);
				end
				side_s[i] <= sp;
			end
		end
	end

	assign v_out = v_s[STAGES-1];
	assign x_out = x_s[STAGES-1];
	assign z_out = z_s[STAGES-1];
	assign side_out = side_s[STAGES-1];

endmodule
`default_nettype wire

// ===== sv/hsr_isqrt.sv =====
`default_nettype none
module hsr_isqrt #(
	parameter int STEPS = 31,
	parameter int SIDE_W = 1
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               v_in,
	input  wire logic [2*STEPS-1:0] radicand,
	input  wire logic [SIDE_W-1:0]  side_in,
	output logic                    v_out,
	output logic [STEPS-1:0]        root,
	output logic [SIDE_W-1:0]       side_out
);
	localparam int RW = 2 * STEPS;

	logic [RW-1:0]     rem_s  [STEPS];
	logic [RW-1:0]     root_s [STEPS];
	logic              v_s    [STEPS];
	logic [SIDE_W-1:0] side_s [STEPS];

	// one result bit per stage, restoring digit recurrence
	for (genvar j = 0; j < STEPS; j++) begin : g_step
		localparam logic [RW-1:0] BIT = RW'(1) << (2 * (STEPS - 1 - j));
		logic [RW-1:0]     remp;
		logic [RW-1:0]     rootp;
		logic [RW-1:0]     trial;
		logic              vp;
		logic [SIDE_W-1:0] sp;

		if (j == 0) begin : g_head
			assign remp = radicand;
			assign rootp = '0;
			assign vp = v_in;
			assign sp = side_in;
		end else begin : g_tail
			assign remp = rem_s[j-1];
			assign rootp = root_s[j-1];
			assign vp = v_s[j-1];
			assign sp = side_s[j-1];
		end

		assign trial = rootp + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) v_s[j] <= 1'b0;
			else if (en) v_s[j] <= vp;
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (remp >= trial) begin
					rem_s[j] <= remp - trial;
					root_s[j] <= (rootp >> 1) + BIT;
				end else begin
					rem_s[j] <= remp;
					root_s[j] <= rootp >> 1;
				end
				side_s[j] <= sp;
			end
		end
	end

	assign v_out = v_s[STEPS-1];
	assign root = root_s[STEPS-1][STEPS-1:0];
	assign side_out = side_s[STEPS-1];

endmodule
`default_nettype wire

// ===== sv/haversine_slant_range.sv =====
// throughput: one transaction per cycle unless a blocked result stalls the pipeline; set by the pipelined units
// a blocked result lets the pipeline keep filling while its last stage is empty
// reset: arst_n clears all valid bits and loads the radius register with 6371000 m
`default_nettype none
module haversine_slant_range #(
	parameter int CORDIC_STAGES = hsr_pkg::CORDIC_STAGES_DEF
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// first_longitude, first_latitude, first_altitude,
	// second_longitude, second_latitude, second_altitude (32 bits each)
	input  wire logic [191:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// slant_range_mm [34:0], zero fill [39:35]
	output logic [39:0]       m_tdata,
	// range_saturated
	output logic              m_tuser,
	input  wire logic         cfg_we,
	input  wire logic [22:0]  cfg_wdata
);
	import hsr_pkg::*;

	localparam longint GAIN_X = cordic_gain_x(CORDIC_STAGES);
	localparam longint GAIN_K = ((longint'(1) <<< 61) + GAIN_X / 2) / GAIN_X;
	localparam logic [30:0] K31 = 31'(GAIN_K);
	localparam q30_t X_INIT = q30_t'({3'b0, K31});
	localparam int HW = 56;

	function automatic logic [CW:0] to_rad(input logic [31:0] a);
		logic signed [32:0] ae;
		logic               neg;
		logic [30:0]        am;
		logic [62:0]        pr;
		q30_t               z;
		ae = signed'({a[31], a});
		neg = 1'b0;
		if (ae > 33'sd1073741824) begin
			ae = ae - 33'sd2147483648;
			neg = 1'b1;
		end else if (ae < -33'sd1073741824) begin
			ae = ae + 33'sd2147483648;
			neg = 1'b1;
		end
		am = ae[32] ? 31'(-ae) : 31'(ae);
		pr = 63'(am) * 63'(PI_Q30) + (63'd1 << 30);
		z = q30_t'({2'b0, pr[62:31]});
		if (ae[32]) z = -z;
		return {neg, z};
	endfunction

	logic        en;
	logic        load_out;
	logic [22:0] radius_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) radius_q <= RADIUS_RESET;
		else if (cfg_we) radius_q <= cfg_wdata;
	end

	// stage 1: differences and halving
	logic [31:0] lon1, lat1, alt1, lon2, lat2, alt2;
	logic [31:0] dlat, dlon;
	logic [32:0] dlat_t, dlon_t, adiff, ualt;
	logic        v_s1;
	logic [31:0] ang_s1 [4];
	logic [32:0] ualt_s1;

	assign {alt2, lat2, lon2, alt1, lat1, lon1} = s_tdata;
	assign dlat = lat2 - lat1;
	assign dlon = lon2 - lon1;
	// halve toward zero
	assign dlat_t = {dlat[31], dlat} + 33'(dlat[31]);
	assign dlon_t = {dlon[31], dlon} + 33'(dlon[31]);
	assign adiff = {alt2[31], alt2} - {alt1[31], alt1};
	assign ualt = adiff[32] ? -adiff : adiff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s1 <= 1'b0;
		else if (en) v_s1 <= s_tvalid;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ang_s1[0] <= dlat_t[32:1];
			ang_s1[1] <= dlon_t[32:1];
			ang_s1[2] <= lat1;
			ang_s1[3] <= lat2;
			ualt_s1 <= ualt;
		end
	end

	// stage 2: fold to the right half plane and scale to radians
	logic        v_s2;
	q30_t        z_s2 [4];
	logic [3:0]  neg_s2;
	logic [32:0] ualt_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_s2 <= 1'b0;
		else if (en) v_s2 <= v_s1;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				{neg_s2[k], z_s2[k]} <= to_rad(ang_s1[k]);
			end
			ualt_s2 <= ualt_s1;
		end
	end

	// sine and cosine units
	logic        v_rot;
	q30_t        rx [4];
	q30_t        ry [4];
	logic [3:0]  rneg;
	logic [32:0] ualt_rot;

	hsr_rot_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(34), .X_INIT(X_INIT)) u_rot0 (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s2), .z_in(z_s2[0]),
		.side_in({ualt_s2, neg_s2[0]}), .v_out(v_rot), .x_out(rx[0]), .y_out(ry[0]),
		.side_out({ualt_rot, rneg[0]})
	);

	for (genvar k = 1; k < 4; k++) begin : g_rot
		hsr_rot_cordic #(.STAGES(CORDIC_STAGES), .SIDE_W(1), .X_INIT(X_INIT)) u_rot (
			.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_s2), .z_in(z_s2[k]),
			.side_in(neg_s2[k]), .v_out(), .x_out(rx[k]), .y_out(ry[k]),
			.side_out(rneg[k])
		);
	end

	// haversine term
	q30_t        slat, slon, cos1, cos2;
	logic        v_p1, v_p2, v_p3;
	q30_t        a_p1, b_p1, e_p1, a_p2, f_p2;
	logic [32:0] ualt_p1, ualt_p2, ualt_p3;
	logic [30:0] h_p3, hc_p3;
	logic signed [34:0] hsum;

	assign slat = rneg[0] ? -ry[0] : ry[0];
	assign slon = rneg[1] ? -ry[1] : ry[1];
	assign cos1 = rneg[2] ? -rx[2] : rx[2];
	assign cos2 = rneg[3] ? -rx[3] : rx[3];
	assign hsum = {a_p2[CW-1], a_p2} + {f_p2[CW-1], f_p2};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_p1 <= 1'b0;
			v_p2 <= 1'b0;
			v_p3 <= 1'b0;
		end else if (en) begin
			v_p1 <= v_rot;
			v_p2 <= v_p1;
			v_p3 <= v_p2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			a_p1 <= mul_q30(slat, slat);
			b_p1 <= mul_q30(cos1, cos2);
			e_p1 <= mul_q30(slon, slon);
			ualt_p1 <= ualt_rot;
			a_p2 <= a_p1;
			f_p2 <= mul_q30(b_p1, e_p1);
			ualt_p2 <= ualt_p1;
			// clamp h to [0, 1]
			if (hsum < 0) begin
				h_p3 <= '0;
				hc_p3 <= 31'h4000_0000;
			end else if (hsum > 35'sd1073741824) begin
				h_p3 <= 31'h4000_0000;
				hc_p3 <= '0;
			end else begin
				h_p3 <= hsum[30:0];
				hc_p3 <= 31'h4000_0000 - hsum[30:0];
			end
			ualt_p3 <= ualt_p2;
		end
	end

	// square roots of h and 1-h
	logic                  v_sq;
	logic [SQRT_STEPS-1:0] root_h, root_hc;
	logic [32:0]           ualt_sq;

	hsr_isqrt #(.STEPS(SQRT_STEPS), .SIDE_W(33)) u_sqrt_h (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_p3),
		.radicand({1'b0, h_p3, 30'b0}), .side_in(ualt_p3),
		.v_out(v_sq), .root(root_h), .side_out(ualt_sq)
	);

	hsr_isqrt #(.STEPS(SQRT_STEPS), .SIDE_W(1)) u_sqrt_hc (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_p3),
		.radicand({1'b0, hc_p3, 30'b0}), .side_in(1'b0),
		.v_out(), .root(root_hc), .side_out()
	);

	// central angle by atan2
	logic             v_ang;
	q30_t             ang_z;
	logic [32:0]      ualt_ang;

	hsr_vec_cordic #(.STAGES(CORDIC_STAGES), .W(CW), .SIDE_W(33)) u_atan (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_sq),
		.x_in({3'b0, root_hc}), .y_in({3'b0, root_h}), .side_in(ualt_sq),
		.v_out(v_ang), .x_out(), .z_out(ang_z), .side_out(ualt_ang)
	);

	// surface distance in mm
	logic        v_d1, v_d2;
	logic [31:0] cang;
	logic [54:0] q_d1;
	logic [35:0] dist_d2;
	logic [39:0] frac_mm;
	logic [32:0] ualt_d1, ualt_d2;

	// negative residue from the last stage clamps to zero
	assign cang = ang_z[CW-1] ? '0 : {ang_z[30:0], 1'b0};
	assign frac_mm = 40'(q_d1[29:0]) * 40'd1000 + (40'd1 << 29);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_d1 <= 1'b0;
			v_d2 <= 1'b0;
		end else if (en) begin
			v_d1 <= v_ang;
			v_d2 <= v_d1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q_d1 <= 55'(radius_q) * 55'(cang);
			ualt_d1 <= ualt_ang;
			dist_d2 <= 36'(35'(q_d1[54:30]) * 35'd1000) + 36'(frac_mm[39:30]);
			ualt_d2 <= ualt_d1;
		end
	end

	// slant range by hypotenuse with 16 guard bits
	logic                 v_hyp;
	logic signed [HW-1:0] hyp_x;

	hsr_vec_cordic #(.STAGES(CORDIC_STAGES), .W(HW), .SIDE_W(1)) u_hyp (
		.clk(clk), .arst_n(arst_n), .en(en), .v_in(v_d2),
		.x_in({4'b0, dist_d2, 16'b0}), .y_in({7'b0, ualt_d2, 16'b0}), .side_in(1'b0),
		.v_out(v_hyp), .x_out(hyp_x), .z_out(), .side_out()
	);

	logic        v_h1;
	logic [54:0] xm;
	logic [55:0] phi_h1;
	logic [60:0] plo_h1;
	logic [56:0] mag;
	logic [40:0] mag_mm;
	logic        sat;

	assign xm = hyp_x[HW-1] ? '0 : hyp_x[54:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) v_h1 <= 1'b0;
		else if (en) v_h1 <= v_hyp;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			phi_h1 <= 56'(xm[54:30]) * 56'(K31);
			plo_h1 <= 61'(xm[29:0]) * 61'(K31) + (61'd1 << 29);
		end
	end

	assign mag = 57'(phi_h1) + 57'(plo_h1[60:30]);
	assign mag_mm = 41'((58'(mag) + (58'd1 << 15)) >> 16);
	assign sat = mag_mm > 41'(RANGE_MAX);

	// output register; the pipeline moves on whenever this register can load or its last stage is empty
	logic        out_v_q;
	logic [34:0] range_q;
	logic        sat_q;

	assign load_out = !out_v_q || m_tready;
	assign en = load_out || !v_h1;
	assign s_tready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_v_q <= 1'b0;
		else if (load_out) out_v_q <= v_h1;
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			range_q <= sat ? RANGE_MAX : mag_mm[34:0];
			sat_q <= sat;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata = {5'b0, range_q};
	assign m_tuser = sat_q;

endmodule
`default_nettype wire

// ===== sv/hsr_checker.sv =====
`default_nettype none
module hsr_checker (
	input wire logic         clk,
	input wire logic         arst_n,
	input wire logic         s_tready,
	input wire logic         m_tvalid,
	input wire logic         m_tready,
	input wire logic [39:0]  m_tdata,
	input wire logic         m_tuser
);

	// a held result stays offered
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	a_sat_max: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata[34:0] == 35'h7_FFFF_FFFF)
		else $error("saturation flag without full-scale range");

	a_pad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[39:35] == 5'd0)
		else $error("pad bits of result not zero");

	// with no result pending the input side must be open
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input blocked with empty output");

endmodule

bind haversine_slant_range hsr_checker u_hsr_checker (.*);
`default_nettype wire
